### design/gpio_ihm_pkg.sv
// ----------------------------------------------------------------------------
// GPIO interrupt handler mux table package
// Field widths, command and status codes, slot and result types, and the
// FSM state type used by the handler table.
// ----------------------------------------------------------------------------
package gpio_ihm_pkg;

  localparam int PORT_W    = 3;
  localparam int PORT_N    = 2 ** PORT_W;
  localparam int PIN_W     = 8;
  localparam int ID_W      = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int SLOT_IDX_W = 2;
  localparam int PRESENT_W = 7;

  localparam int DEF_SLOTS_PER_PORT = 4;
  localparam int DEF_NUM_PORTS      = 7;
  localparam int PINS_PER_PORT      = 8;
  localparam int MAX_RESULTS        = 4;

  localparam logic [PIN_W-1:0] PIN_LIMIT =
    PIN_W'((64'(1) << PINS_PER_PORT) - 64'(1));
  localparam logic [PRESENT_W-1:0] PRESENT_RESET = PRESENT_W'(45);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_ATTACH   = 2'd0;
  localparam cmd_t CMD_DETACH   = 2'd1;
  localparam cmd_t CMD_DISPATCH = 2'd2;
  localparam cmd_t CMD_UNKNOWN  = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_PORT = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NO_MATCH = 2'd3;

  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic [ID_W-1:0]  arg;
    logic [ID_W-1:0]  handler;
  } slot_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [ID_W-1:0]       handler;
    logic [ID_W-1:0]       arg;
    logic [PIN_W-1:0]      clr;
    logic [PIN_W-1:0]      en;
    logic [PIN_W-1:0]      dis;
    logic [PIN_W-1:0]      sense;
    logic                  last;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT,
    S_DISP
  } state_t;

endpackage

### design/gpio_ihm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module gpio_ihm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/gpio_interrupt_handler_mux_table.sv
// ----------------------------------------------------------------------------
// GPIO interrupt handler mux table
// Per-port table of handler slots kept as one RAM row per port. Commands
// attach or detach handler pins, or dispatch raised flags to the handlers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | command in tuser, operands in tdata
//  m_*     | out       | m_tvalid/m_tready  | result in tdata, tlast on final one
//  cfg_*   | in        | cfg_we             | ports_present register
//
// Attach, detach and error items are accepted with the row read, then the
// row is updated and written back, then the result is loaded for output.
// A dispatch is accepted with the row read, then yields one result per
// matching slot in slot order, up to four results. Each item uses one RAM row.
// After reset every row reads as empty through per-port valid flops.
// A stalled output holds the block in its result states until taken.
module gpio_interrupt_handler_mux_table
  import gpio_ihm_pkg::*;
#(
  parameter int SLOTS_PER_PORT = DEF_SLOTS_PER_PORT,
  parameter int NUM_PORTS      = DEF_NUM_PORTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PRESENT_W-1:0]  cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // port, pin_mask, handler_id, arg_id, sense_config, keep_slot, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, slot_index, handler_out, arg_out, flags_clear_mask, enable_mask,
  // disable_mask, sense_out, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int AW     = NUM_PORTS > 1 ? $clog2(NUM_PORTS) : 1;
  localparam int SIW    = SLOTS_PER_PORT > 1 ? $clog2(SLOTS_PER_PORT) : 1;
  localparam int ROW_W  = SLOTS_PER_PORT * $bits(slot_t);
  localparam int CNT_W  = $clog2(MAX_RESULTS);
  localparam logic [PORT_W:0] NUM_PORTS_C = (PORT_W + 1)'(NUM_PORTS);

  state_t state, state_next;

  logic [PRESENT_W-1:0]      ports_present;
  logic [NUM_PORTS-1:0]      in_use;
  logic [NUM_PORTS-1:0]      row_ok;

  cmd_t                      in_cmd;
  logic [PORT_W-1:0]         in_port;
  logic [PIN_W-1:0]          in_pins;
  logic [ID_W-1:0]           in_hnd;
  logic [ID_W-1:0]           in_arg;
  logic [PIN_W-1:0]          in_sense;
  logic                      in_keep;

  result_t                   res;
  result_t                   out_q;
  slot_t [SLOTS_PER_PORT-1:0] row_q;
  logic [SLOTS_PER_PORT-1:0] rem_q;
  logic [CNT_W-1:0]          n_cnt;

  logic                      accept;
  logic                      out_free;
  logic                      ram_re;
  logic                      ram_we;
  logic [ROW_W-1:0]          ram_rdata;

  logic [PORT_N-1:0]         present_pad;
  logic [PORT_N-1:0]         in_use_pad;
  logic [PORT_N-1:0]         row_ok_pad;
  logic [NUM_PORTS-1:0]      port_dec;
  logic                      port_in_range;

  slot_t [SLOTS_PER_PORT-1:0] row_rd;
  slot_t [SLOTS_PER_PORT-1:0] row_att;
  slot_t [SLOTS_PER_PORT-1:0] row_det;
  slot_t [SLOTS_PER_PORT-1:0] row_wr;
  logic [SLOTS_PER_PORT-1:0] match;
  logic                      hit_found;
  logic                      free_found;
  logic [SIW-1:0]            hit_idx;
  logic [SIW-1:0]            free_idx;
  logic [SIW-1:0]            att_idx;

  result_t                   exec_res;
  logic                      exec_we;
  logic                      exec_disp;
  logic                      exec_set_use;

  logic [SIW-1:0]            sel_idx;
  logic [SLOTS_PER_PORT-1:0] rem_after;
  logic                      disp_last;
  result_t                   disp_res;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign present_pad   = PORT_N'(ports_present);
  assign in_use_pad    = PORT_N'(in_use);
  assign row_ok_pad    = PORT_N'(row_ok);
  assign port_dec      = NUM_PORTS'(PORT_N'(1) << in_port);
  assign port_in_range = {1'b0, in_port} < NUM_PORTS_C;

  gpio_ihm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_PORTS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_port[AW-1:0]),
    .wdata(row_wr),
    .re   (ram_re),
    .raddr(s_tdata[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign row_rd = row_ok_pad[in_port] ? ram_rdata : '0;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS_PER_PORT; i++) begin
      if (row_rd[i].handler == '0) begin
        if (!free_found) begin
          free_found = 1'b1;
          free_idx   = SIW'(i);
        end
      end else if (!hit_found && row_rd[i].handler == in_hnd &&
                   row_rd[i].arg == in_arg) begin
        hit_found = 1'b1;
        hit_idx   = SIW'(i);
      end
    end
  end

  always_comb begin
    row_att = row_rd;
    att_idx = hit_found ? hit_idx : free_idx;
    if (hit_found) begin
      row_att[hit_idx].pins = row_rd[hit_idx].pins | in_pins;
    end else if (free_found) begin
      row_att[free_idx] = '{pins: in_pins, arg: in_arg, handler: in_hnd};
    end
  end

  always_comb begin
    row_det = row_rd;
    for (int i = 0; i < SLOTS_PER_PORT; i++) begin
      if ((row_rd[i].pins & in_pins) != '0) begin
        row_det[i].pins = row_rd[i].pins & ~in_pins;
        if (row_det[i].pins == '0 && !in_keep) begin
          row_det[i].handler = '0;
          row_det[i].arg     = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS_PER_PORT; i++) begin
      match[i] = (row_rd[i].handler != '0) && ((row_rd[i].pins & in_pins) != '0);
    end
  end

  always_comb begin
    exec_res        = '0;
    exec_res.last   = 1'b1;
    exec_we         = 1'b0;
    exec_disp       = 1'b0;
    exec_set_use    = 1'b0;
    row_wr          = row_det;
    if (!port_in_range) begin
      exec_res.status = ST_BAD_PORT;
    end else begin
      unique case (in_cmd)
        CMD_ATTACH: begin
          row_wr = row_att;
          if (!present_pad[in_port]) begin
            exec_res.status = ST_BAD_PORT;
          end else begin
            exec_set_use = 1'b1;
            if (!hit_found && !free_found) begin
              exec_res.status = ST_FULL;
            end else begin
              exec_we        = 1'b1;
              exec_res.slot  = SLOT_IDX_W'(att_idx);
              exec_res.clr   = in_pins;
              exec_res.en    = in_pins;
              exec_res.dis   = in_pins;
              exec_res.sense = in_sense;
            end
          end
        end
        CMD_DETACH: begin
          if (!in_use_pad[in_port]) begin
            exec_res.status = ST_BAD_PORT;
          end else begin
            exec_we      = 1'b1;
            exec_res.clr = in_pins;
            exec_res.dis = in_pins;
          end
        end
        default: begin
          if (!in_use_pad[in_port]) begin
            exec_res.status = ST_BAD_PORT;
          end else if (match == '0) begin
            exec_res.status = ST_NO_MATCH;
            exec_res.clr    = in_pins;
          end else begin
            exec_disp = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    sel_idx = '0;
    for (int i = SLOTS_PER_PORT - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel_idx = SIW'(i);
      end
    end
    rem_after        = rem_q & ~(SLOTS_PER_PORT'(1) << sel_idx);
    disp_last        = (rem_after == '0) || (n_cnt == CNT_W'(MAX_RESULTS - 1));
    disp_res         = '0;
    disp_res.status  = ST_OK;
    disp_res.slot    = SLOT_IDX_W'(sel_idx);
    disp_res.handler = row_q[sel_idx].handler;
    disp_res.arg     = row_q[sel_idx].arg;
    disp_res.clr     = (n_cnt == '0) ? in_pins : '0;
    disp_res.last    = disp_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && s_tuser != CMD_UNKNOWN) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = exec_disp ? S_DISP : S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free && disp_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
      end
      S_EXEC: begin
        ram_we = exec_we;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ports_present <= PRESENT_RESET;
      in_use        <= '0;
      row_ok        <= '0;
      rem_q         <= '0;
      n_cnt         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ports_present <= cfg_wdata;
      end
      if (state == S_EXEC) begin
        if (exec_set_use) begin
          in_use <= in_use | port_dec;
        end
        if (exec_we) begin
          row_ok <= row_ok | port_dec;
        end
        rem_q <= exec_disp ? match : '0;
        n_cnt <= '0;
      end else if (state == S_DISP && out_free) begin
        rem_q <= rem_after;
        n_cnt <= n_cnt + CNT_W'(1);
      end
      if ((state == S_OUT || state == S_DISP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd   <= s_tuser;
      in_port  <= s_tdata[2:0];
      in_pins  <= s_tdata[10:3] & PIN_LIMIT;
      in_hnd   <= s_tdata[18:11];
      in_arg   <= s_tdata[26:19];
      in_sense <= s_tdata[34:27];
      in_keep  <= s_tdata[35];
    end
    if (state == S_EXEC) begin
      res   <= exec_res;
      row_q <= row_rd;
    end
    if (state == S_OUT && out_free) begin
      out_q <= res;
    end else if (state == S_DISP && out_free) begin
      out_q <= disp_res;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_q.sense, out_q.dis, out_q.en, out_q.clr,
                                out_q.arg, out_q.handler, out_q.slot, out_q.status});
  assign m_tlast = out_q.last;

  a_unknown_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == CMD_UNKNOWN) |=> state == S_IDLE)
    else $error("unknown command left the idle state");

  a_write_then_result: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> state == S_OUT)
    else $error("row write not followed by a result");

  a_disp_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_DISP |-> rem_q != '0)
    else $error("dispatch state with no matching slot left");

  a_disp_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && out_free) |=> m_tvalid)
    else $error("dispatch result not presented");

endmodule
